FILE: sv/rtnp_pkg.sv
// Shared types, constants and character codes for the ringtone text note parser.
package rtnp_pkg;

  // Number handling
  localparam int                  MAX_DIGITS   = 4;
  localparam int                  CNT_W        = 3;
  localparam logic [CNT_W-1:0]    COUNT_CLOSED = CNT_W'(7);
  localparam logic [CNT_W-1:0]    MAX_DIGITS_C = CNT_W'(MAX_DIGITS);
  localparam int                  NUM_W        = 14;
  localparam logic [NUM_W-1:0]    NUM_MAX      = NUM_W'(9999);
  localparam logic [3:0]          OCT_MAX      = 4'd15;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Special characters
  localparam logic [7:0] CH_NUL_C   = 8'h00;
  localparam logic [7:0] CH_COLON_C = 8'h3A;
  localparam logic [7:0] CH_EQUAL_C = 8'h3D;
  localparam logic [7:0] CH_COMMA_C = 8'h2C;
  localparam logic [7:0] CH_DOT_C   = 8'h2E;
  localparam logic [7:0] CH_HASH_C  = 8'h23;
  localparam logic [7:0] CH_SPACE_C = 8'h20;
  localparam logic [7:0] CH_ZERO_C  = 8'h30;
  localparam logic [7:0] CH_NINE_C  = 8'h39;

  // Note codes
  localparam logic [3:0] NOTE_PAUSE = 4'd0;
  localparam logic [3:0] NOTE_C     = 4'd1;
  localparam logic [3:0] NOTE_D     = 4'd3;
  localparam logic [3:0] NOTE_E     = 4'd5;
  localparam logic [3:0] NOTE_F     = 4'd6;
  localparam logic [3:0] NOTE_G     = 4'd8;
  localparam logic [3:0] NOTE_A     = 4'd10;
  localparam logic [3:0] NOTE_H     = 4'd12;

  // Character class
  typedef enum logic [3:0] {
    CLS_NUL,
    CLS_COMMA,
    CLS_COLON,
    CLS_EQUAL,
    CLS_DOT,
    CLS_HASH,
    CLS_SPACE,
    CLS_DIGIT,
    CLS_OTHER
  } char_cls_t;

  // One classified character
  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] digit;
    logic [3:0] letter;
    logic       sharp_ok;
    logic       restart;
  } token_t;

endpackage

FILE: sv/rtnp_if.sv
// Channel interfaces: ringtone text input and parsed note output.
interface rtnp_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       restart;

  modport source (output valid, output text_char, output restart, input ready);
  modport sink   (input valid, input text_char, input restart, output ready);
endinterface

interface rtnp_note_if;
  logic        valid;
  logic        ready;
  logic [3:0]  note_code;
  logic [3:0]  octave_number;
  logic [13:0] note_divisor;
  logic        dotted;
  logic [13:0] tempo_bpm;
  logic        song_end;

  modport source (output valid, output note_code, output octave_number,
                  output note_divisor, output dotted, output tempo_bpm,
                  output song_end, input ready);
  modport sink   (input valid, input note_code, input octave_number,
                  input note_divisor, input dotted, input tempo_bpm,
                  input song_end, output ready);
endinterface

FILE: sv/rtnp_front.sv
// Front end: accepts text bytes and classifies them into tokens.
module rtnp_front (
  rtnp_text_if.sink         text,
  input  logic              q_ready,
  output logic              q_push,
  output rtnp_pkg::token_t  q_token
);
  import rtnp_pkg::*;

  char_cls_t  cls;
  logic [3:0] letter;
  logic       sharp_ok;
  logic [7:0] digit_full;

  // Handshake straight into the queue
  assign text.ready = q_ready;
  assign q_push     = text.valid && q_ready;

  // Character class
  always_comb begin
    if (text.text_char >= CH_ZERO_C && text.text_char <= CH_NINE_C) begin
      cls = CLS_DIGIT;
    end else begin
      unique case (text.text_char)
        CH_NUL_C:   cls = CLS_NUL;
        CH_COMMA_C: cls = CLS_COMMA;
        CH_COLON_C: cls = CLS_COLON;
        CH_EQUAL_C: cls = CLS_EQUAL;
        CH_DOT_C:   cls = CLS_DOT;
        CH_HASH_C:  cls = CLS_HASH;
        CH_SPACE_C: cls = CLS_SPACE;
        default:    cls = CLS_OTHER;
      endcase
    end
  end

  // Note letter decode; anything unknown is a pause
  always_comb begin
    sharp_ok = 1'b0;
    unique case (text.text_char)
      "c": begin letter = NOTE_C; sharp_ok = 1'b1; end
      "d": begin letter = NOTE_D; sharp_ok = 1'b1; end
      "e": letter = NOTE_E;
      "f": begin letter = NOTE_F; sharp_ok = 1'b1; end
      "g": begin letter = NOTE_G; sharp_ok = 1'b1; end
      "a": begin letter = NOTE_A; sharp_ok = 1'b1; end
      "h", "b": letter = NOTE_H;
      default: letter = NOTE_PAUSE;
    endcase
  end

  assign digit_full = text.text_char - CH_ZERO_C;

  assign q_token.cls      = cls;
  assign q_token.digit    = digit_full[3:0];
  assign q_token.letter   = letter;
  assign q_token.sharp_ok = sharp_ok;
  assign q_token.restart  = text.restart;

endmodule

FILE: sv/rtnp_queue.sv
// Short token queue between the classifier and the parser.
module rtnp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rtnp_pkg::token_t  push_token,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output rtnp_pkg::token_t  pop_token
);
  import rtnp_pkg::*;

  token_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_token  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/rtnp_back.sv
// Back end: header and note parser state machine with the output register.
module rtnp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  input  rtnp_pkg::token_t  tok,
  output logic              tok_pop,
  rtnp_note_if.source       note
);
  import rtnp_pkg::*;

  typedef enum logic [3:0] {
    PH_TITLE,
    PH_EQ_DUR,
    PH_NUM_DUR,
    PH_EQ_OCT,
    PH_NUM_OCT,
    PH_EQ_TEMPO,
    PH_NUM_TEMPO,
    PH_NOTE_START,
    PH_NOTE_DIGITS,
    PH_AFTER_LETTER,
    PH_AFTER_DOT,
    PH_AFTER_OCT
  } phase_t;

  phase_t            phase, phase_next;
  logic [NUM_W-1:0]  default_divisor, default_divisor_next;
  logic [3:0]        hdr_octave, hdr_octave_next;
  logic [NUM_W-1:0]  tempo_value, tempo_value_next;
  logic [NUM_W-1:0]  acc, acc_next;
  logic [CNT_W-1:0]  digit_count, digit_count_next;
  logic [3:0]        pend_code, pend_code_next;
  logic [3:0]        pend_octave, pend_octave_next;
  logic [NUM_W-1:0]  pend_divisor, pend_divisor_next;
  logic              pend_dotted, pend_dotted_next;
  logic              sharp_allowed, sharp_allowed_next;

  logic              emit;
  logic              emit_end;
  logic [NUM_W-1:0]  emit_divisor;
  logic [NUM_W-1:0]  acc_added;
  logic              is_term;

  // acc * 10 + digit, saturated
  function automatic logic [NUM_W-1:0] acc_step(logic [NUM_W-1:0] a, logic [3:0] d);
    logic [NUM_W+3:0] v;
    v = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{NUM_W{1'b0}}, d};
    return (v > {4'b0, NUM_MAX}) ? NUM_MAX : v[NUM_W-1:0];
  endfunction

  assign tok_pop   = tok_valid && (!note.valid || note.ready);
  assign acc_added = acc_step(acc, tok.digit);
  assign is_term   = (tok.cls == CLS_NUL) || (tok.cls == CLS_COMMA);

  // Next-state logic
  always_comb begin
    phase_next           = phase;
    default_divisor_next = default_divisor;
    hdr_octave_next      = hdr_octave;
    tempo_value_next     = tempo_value;
    acc_next             = acc;
    digit_count_next     = digit_count;
    pend_code_next       = pend_code;
    pend_octave_next     = pend_octave;
    pend_divisor_next    = pend_divisor;
    pend_dotted_next     = pend_dotted;
    sharp_allowed_next   = sharp_allowed;
    emit                 = 1'b0;
    emit_end             = (tok.cls == CLS_NUL);
    emit_divisor         = (phase == PH_NOTE_DIGITS) ? acc : pend_divisor;

    if (tok.restart) begin
      // New ringtone: everything back to reset, byte taken as a title byte
      default_divisor_next = '0;
      hdr_octave_next      = '0;
      tempo_value_next     = '0;
      acc_next             = '0;
      digit_count_next     = '0;
      pend_code_next       = '0;
      pend_octave_next     = '0;
      pend_divisor_next    = '0;
      pend_dotted_next     = 1'b0;
      sharp_allowed_next   = 1'b0;
      phase_next           = (tok.cls == CLS_COLON) ? PH_EQ_DUR : PH_TITLE;
    end else begin
      unique case (phase)
        PH_EQ_DUR, PH_EQ_OCT, PH_EQ_TEMPO: begin
          if (tok.cls == CLS_EQUAL) begin
            acc_next         = '0;
            digit_count_next = '0;
            phase_next       = (phase == PH_EQ_DUR) ? PH_NUM_DUR :
                               (phase == PH_EQ_OCT) ? PH_NUM_OCT : PH_NUM_TEMPO;
          end
        end

        PH_NUM_DUR, PH_NUM_OCT, PH_NUM_TEMPO: begin
          if ((phase != PH_NUM_TEMPO && tok.cls == CLS_COMMA) ||
              (phase == PH_NUM_TEMPO && tok.cls == CLS_COLON)) begin
            if (phase == PH_NUM_DUR) begin
              default_divisor_next = acc;
              phase_next           = PH_EQ_OCT;
            end else if (phase == PH_NUM_OCT) begin
              hdr_octave_next = (acc > NUM_W'(OCT_MAX)) ? OCT_MAX : acc[3:0];
              phase_next      = PH_EQ_TEMPO;
            end else begin
              // Header done: open the first note
              tempo_value_next   = acc;
              acc_next           = '0;
              digit_count_next   = '0;
              pend_code_next     = NOTE_PAUSE;
              pend_octave_next   = hdr_octave;
              pend_divisor_next  = default_divisor;
              pend_dotted_next   = 1'b0;
              sharp_allowed_next = 1'b0;
              phase_next         = PH_NOTE_START;
            end
          end else if (tok.cls == CLS_SPACE) begin
            // dropped
          end else if (tok.cls == CLS_DIGIT) begin
            if (digit_count != COUNT_CLOSED) begin
              if (digit_count < MAX_DIGITS_C) begin
                acc_next         = acc_added;
                digit_count_next = digit_count + 1'b1;
              end else begin
                acc_next = NUM_MAX;
              end
            end
          end else begin
            digit_count_next = COUNT_CLOSED;
          end
        end

        PH_NOTE_START, PH_NOTE_DIGITS: begin
          if (is_term) begin
            emit = 1'b1;
          end else if (tok.cls == CLS_DIGIT) begin
            if (digit_count < MAX_DIGITS_C) begin
              acc_next         = acc_added;
              digit_count_next = digit_count + 1'b1;
            end else begin
              acc_next = NUM_MAX;
            end
            phase_next = PH_NOTE_DIGITS;
          end else if (tok.cls == CLS_SPACE && phase == PH_NOTE_START) begin
            // leading space dropped
          end else begin
            if (phase == PH_NOTE_DIGITS) begin
              pend_divisor_next = acc;
            end
            pend_code_next     = tok.letter;
            sharp_allowed_next = tok.sharp_ok;
            phase_next         = PH_AFTER_LETTER;
          end
        end

        PH_AFTER_LETTER, PH_AFTER_DOT, PH_AFTER_OCT: begin
          if (is_term) begin
            emit = 1'b1;
          end else begin
            sharp_allowed_next = 1'b0;
            if (phase == PH_AFTER_LETTER && tok.cls == CLS_HASH && sharp_allowed) begin
              pend_code_next = pend_code + 1'b1;
            end else if (phase == PH_AFTER_LETTER && tok.cls == CLS_DOT) begin
              pend_dotted_next = 1'b1;
              phase_next       = PH_AFTER_DOT;
            end else if (phase != PH_AFTER_OCT && tok.cls == CLS_DIGIT) begin
              pend_octave_next = tok.digit;
              phase_next       = PH_AFTER_OCT;
            end
          end
        end

        default: begin
          phase_next = (tok.cls == CLS_COLON) ? PH_EQ_DUR : PH_TITLE;
        end
      endcase

      // Emitting a note opens the next one
      if (emit) begin
        acc_next           = '0;
        digit_count_next   = '0;
        pend_code_next     = NOTE_PAUSE;
        pend_octave_next   = hdr_octave;
        pend_divisor_next  = default_divisor;
        pend_dotted_next   = 1'b0;
        sharp_allowed_next = 1'b0;
        phase_next         = PH_NOTE_START;
      end
    end
  end

  // Parser state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TITLE;
      default_divisor <= '0;
      hdr_octave      <= '0;
      tempo_value     <= '0;
      acc             <= '0;
      digit_count     <= '0;
      pend_code       <= '0;
      pend_octave     <= '0;
      pend_divisor    <= '0;
      pend_dotted     <= 1'b0;
      sharp_allowed   <= 1'b0;
      note.valid      <= 1'b0;
    end else begin
      if (tok_pop) begin
        phase           <= phase_next;
        default_divisor <= default_divisor_next;
        hdr_octave      <= hdr_octave_next;
        tempo_value     <= tempo_value_next;
        acc             <= acc_next;
        digit_count     <= digit_count_next;
        pend_code       <= pend_code_next;
        pend_octave     <= pend_octave_next;
        pend_divisor    <= pend_divisor_next;
        pend_dotted     <= pend_dotted_next;
        sharp_allowed   <= sharp_allowed_next;
      end
      if (tok_pop && emit) begin
        note.valid <= 1'b1;
      end else if (note.ready) begin
        note.valid <= 1'b0;
      end
    end
    if (tok_pop && emit) begin
      note.note_code     <= pend_code;
      note.octave_number <= pend_octave;
      note.note_divisor  <= emit_divisor;
      note.dotted        <= pend_dotted;
      note.tempo_bpm     <= tempo_value;
      note.song_end      <= emit_end;
    end
  end

  // Checks
  a_reset_title: assert property (@(posedge clk) $past(rst) |-> phase == PH_TITLE)
    else $error("parser not in title after reset");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= MAX_DIGITS_C || digit_count == COUNT_CLOSED)
    else $error("digit count out of range");
  a_acc_sat: assert property (@(posedge clk) disable iff (rst) acc <= NUM_MAX)
    else $error("number accumulator above saturation");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    tok_pop && emit |=> note.valid)
    else $error("emitted note not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    note.valid && !note.ready |-> !tok_pop)
    else $error("token consumed while output held");

endmodule

FILE: sv/ringtone_text_note_parser.sv
// Top level of the ringtone text note parser: classifier, token queue, parser.
//
//   Channel  Modport          Transaction
//   text     rtnp_text_if     one text byte plus restart flag, in
//   note     rtnp_note_if     one parsed note with tempo and song end flag, out
//
// One byte per cycle sustained while the note output does not stall; a note leaves
// after its closing byte has passed the token queue and the output register. The
// parser state machine handles one token per cycle unless held, and sets the rate.
// Synchronous reset returns the parser to the title section and empties the queue.
// A stalled note output holds the parser; the queue then fills and drops text.ready.
module ringtone_text_note_parser (
  input  logic         clk,
  input  logic         rst,
  rtnp_text_if.sink    text,
  rtnp_note_if.source  note
);
  import rtnp_pkg::*;

  logic   q_ready;
  logic   q_push;
  token_t q_token;
  logic   q_valid;
  logic   q_pop;
  token_t q_head;

  rtnp_front u_front (
    .text    (text),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_token (q_token)
  );

  rtnp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_token (q_token),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_token  (q_head)
  );

  rtnp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (q_head),
    .tok_pop   (q_pop),
    .note      (note)
  );

endmodule

FILE: tb/tb_ringtone_text_note_parser.sv
// Testbench for the ringtone text note parser: random ringtones against a note predictor.
`timescale 1ns / 1ps

import rtnp_pkg::*;

// Parser sections, in the order the text walks through them
typedef enum logic [3:0] {
  SEC_TITLE,
  SEC_DUR_EQ,
  SEC_DUR_NUM,
  SEC_OCT_EQ,
  SEC_OCT_NUM,
  SEC_TEMPO_EQ,
  SEC_TEMPO_NUM,
  SEC_NOTE_START,
  SEC_NOTE_DIGITS,
  SEC_AFTER_LETTER,
  SEC_AFTER_DOT,
  SEC_AFTER_OCT
} section_t;

typedef struct packed {
  logic [3:0]  code;
  logic [3:0]  octave;
  logic [13:0] divisor;
  logic        dotted;
  logic [13:0] tempo;
  logic        song_end;
} note_t;

// Note predictor plus the queue of notes still owed by the block
class note_scoreboard;
  section_t    section;
  logic [13:0] dflt_div;
  logic [3:0]  dflt_oct;
  logic [13:0] tempo;
  logic [13:0] acc;
  logic [2:0]  ndig;
  logic [3:0]  pend_code;
  logic [3:0]  pend_oct;
  logic [13:0] pend_div;
  logic        pend_dot;
  logic        sharp_ok;
  note_t       expected_notes[$];
  int          errors;

  function new();
    errors = 0;
    clear_all();
  endfunction

  function void clear_all();
    section   = SEC_TITLE;
    dflt_div  = '0;
    dflt_oct  = '0;
    tempo     = '0;
    acc       = '0;
    ndig      = '0;
    pend_code = '0;
    pend_oct  = '0;
    pend_div  = '0;
    pend_dot  = 1'b0;
    sharp_ok  = 1'b0;
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= CH_ZERO_C && c <= CH_NINE_C;
  endfunction

  // Decimal accumulate, saturating at 9999 or when too many digits arrive
  function void add_digit(logic [7:0] c);
    int v;
    if (ndig >= COUNT_CLOSED) return;
    if (ndig < MAX_DIGITS_C) begin
      v = int'(acc) * 10 + int'(c - CH_ZERO_C);
      acc = (v > int'(NUM_MAX)) ? NUM_MAX : 14'(v);
      ndig = ndig + 3'd1;
    end else begin
      acc = NUM_MAX;
    end
  endfunction

  function void start_note();
    acc       = '0;
    ndig      = '0;
    pend_code = NOTE_PAUSE;
    pend_oct  = dflt_oct;
    pend_div  = dflt_div;
    pend_dot  = 1'b0;
    sharp_ok  = 1'b0;
    section   = SEC_NOTE_START;
  endfunction

  function void take_letter(logic [7:0] c);
    pend_code = NOTE_PAUSE;
    sharp_ok  = 1'b0;
    case (c)
      "c": begin pend_code = NOTE_C; sharp_ok = 1'b1; end
      "d": begin pend_code = NOTE_D; sharp_ok = 1'b1; end
      "e": pend_code = NOTE_E;
      "f": begin pend_code = NOTE_F; sharp_ok = 1'b1; end
      "g": begin pend_code = NOTE_G; sharp_ok = 1'b1; end
      "a": begin pend_code = NOTE_A; sharp_ok = 1'b1; end
      "h", "b": pend_code = NOTE_H;
      default: pend_code = NOTE_PAUSE;
    endcase
    section = SEC_AFTER_LETTER;
  endfunction

  function void emit_note(bit at_end);
    note_t n;
    n.code     = pend_code;
    n.octave   = pend_oct;
    n.divisor  = pend_div;
    n.dotted   = pend_dot;
    n.tempo    = tempo;
    n.song_end = at_end;
    expected_notes.push_back(n);
    start_note();
  endfunction

  // Header number: spaces dropped, a stray character closes it
  function bit header_char(logic [7:0] c, logic [7:0] term);
    if (c == term) return 1'b1;
    if (c == CH_SPACE_C) return 1'b0;
    if (is_digit(c)) add_digit(c);
    else ndig = COUNT_CLOSED;
    return 1'b0;
  endfunction

  // One accepted text transaction
  function void take_text(logic [7:0] c, bit rs);
    bit ends;
    if (rs) clear_all();
    ends = (c == CH_NUL_C) || (c == CH_COMMA_C);
    case (section)
      SEC_DUR_EQ, SEC_OCT_EQ, SEC_TEMPO_EQ: begin
        if (c == CH_EQUAL_C) begin
          acc = '0;
          ndig = '0;
          section = section_t'(section + 4'd1);
        end
      end
      SEC_DUR_NUM: begin
        if (header_char(c, CH_COMMA_C)) begin
          dflt_div = acc;
          section = SEC_OCT_EQ;
        end
      end
      SEC_OCT_NUM: begin
        if (header_char(c, CH_COMMA_C)) begin
          dflt_oct = (acc > 14'(OCT_MAX)) ? OCT_MAX : acc[3:0];
          section = SEC_TEMPO_EQ;
        end
      end
      SEC_TEMPO_NUM: begin
        if (header_char(c, CH_COLON_C)) begin
          tempo = acc;
          start_note();
        end
      end
      SEC_NOTE_START, SEC_NOTE_DIGITS: begin
        if (ends) begin
          if (section == SEC_NOTE_DIGITS) pend_div = acc;
          emit_note(c == CH_NUL_C);
        end else if (is_digit(c)) begin
          add_digit(c);
          section = SEC_NOTE_DIGITS;
        end else if (!(c == CH_SPACE_C && section == SEC_NOTE_START)) begin
          if (section == SEC_NOTE_DIGITS) pend_div = acc;
          take_letter(c);
        end
      end
      SEC_AFTER_LETTER, SEC_AFTER_DOT, SEC_AFTER_OCT: begin
        if (ends) begin
          emit_note(c == CH_NUL_C);
        end else if (section == SEC_AFTER_LETTER && c == CH_HASH_C && sharp_ok) begin
          pend_code = pend_code + 4'd1;
          sharp_ok = 1'b0;
        end else if (section == SEC_AFTER_LETTER && c == CH_DOT_C) begin
          pend_dot = 1'b1;
          sharp_ok = 1'b0;
          section = SEC_AFTER_DOT;
        end else if (section != SEC_AFTER_OCT && is_digit(c)) begin
          pend_oct = 4'(c - CH_ZERO_C);
          sharp_ok = 1'b0;
          section = SEC_AFTER_OCT;
        end else begin
          sharp_ok = 1'b0;
        end
      end
      default: section = (c == CH_COLON_C) ? SEC_DUR_EQ : SEC_TITLE;
    endcase
  endfunction

  task report(string what);
    if (errors < 40) $display("mismatch: %s", what);
    errors++;
  endtask

  // One accepted note transaction against the oldest prediction
  task check_note(note_t got);
    note_t exp;
    if (expected_notes.size() == 0) begin
      report($sformatf("note with none expected: code %0d oct %0d div %0d",
                       got.code, got.octave, got.divisor));
      return;
    end
    exp = expected_notes.pop_front();
    if (got.code !== exp.code || got.octave !== exp.octave ||
        got.divisor !== exp.divisor || got.dotted !== exp.dotted ||
        got.tempo !== exp.tempo || got.song_end !== exp.song_end)
      report($sformatf("code %0d/%0d oct %0d/%0d div %0d/%0d dot %0d/%0d bpm %0d/%0d end %0d/%0d",
                       got.code, exp.code, got.octave, exp.octave, got.divisor, exp.divisor,
                       got.dotted, exp.dotted, got.tempo, exp.tempo,
                       got.song_end, exp.song_end));
  endtask

  task check_leftover();
    if (expected_notes.size() != 0)
      report($sformatf("%0d notes never arrived", expected_notes.size()));
  endtask
endclass

module tb_ringtone_text_note_parser;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [7:0] ch;
    bit         rs;
  } text_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   src_calm = 0;
  int   snk_calm = 0;

  text_item_t      text_items[$];
  note_scoreboard  sb;

  rtnp_text_if text_ch ();
  rtnp_note_if note_ch ();

  ringtone_text_note_parser dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_ch),
    .note (note_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle gap per transaction, with occasional stretches of back-to-back
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Stimulus builders
  function automatic void put(logic [7:0] c, bit rs = 1'b0);
    text_item_t it;
    it.ch = c;
    it.rs = rs;
    text_items.push_back(it);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_digit();
    put(8'($urandom_range(int'(CH_ZERO_C), int'(CH_NINE_C))));
  endfunction

  function automatic void put_number();
    int n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) put(CH_SPACE_C);
      put_digit();
    end
    if ($urandom_range(0, 11) == 0) begin
      put("x");
      put_digit();
    end
    if ($urandom_range(0, 15) == 0) put(CH_NUL_C);
  endfunction

  function automatic void put_key(string key);
    put_str(key);
    if ($urandom_range(0, 9) == 0) put(CH_SPACE_C);
    put(CH_EQUAL_C);
  endfunction

  function automatic void put_note();
    string letters = "cdefgahbp";
    string strays  = "#.7 x";
    int nd = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) put(CH_SPACE_C);
    for (int i = 0; i < nd; i++) put_digit();
    if ($urandom_range(0, 9) == 0) begin
      c = 8'($urandom_range(1, 255));
      put((c == CH_COMMA_C) ? 8'("p") : c);
    end else if ($urandom_range(0, 15) != 0) begin
      put(letters[$urandom_range(0, letters.len() - 1)]);
    end
    if ($urandom_range(0, 2) == 0) put(CH_HASH_C);
    if ($urandom_range(0, 2) == 0) put(CH_DOT_C);
    if ($urandom_range(0, 1) == 0) put_digit();
    if ($urandom_range(0, 9) == 0) put(strays[$urandom_range(0, strays.len() - 1)]);
  endfunction

  // A whole ringtone, first byte marked as restart; sometimes with a second run of notes
  function automatic void put_song();
    int tl = $urandom_range(0, 4);
    int rounds = ($urandom_range(0, 3) == 0) ? 2 : 1;
    int n;
    if (tl == 0) begin
      put(CH_COLON_C, 1'b1);
    end else begin
      put(8'($urandom_range(int'("a"), int'("z"))), 1'b1);
      for (int i = 1; i < tl; i++)
        put(($urandom_range(0, 4) == 0) ? CH_SPACE_C : 8'($urandom_range(int'("a"), int'("z"))));
      put(CH_COLON_C);
    end
    put_key("d");
    put_number();
    put(CH_COMMA_C);
    put_key("o");
    put_number();
    put(CH_COMMA_C);
    put_key("b");
    put_number();
    put(CH_COLON_C);
    for (int r = 0; r < rounds; r++) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        put_note();
        put((i == n - 1) ? CH_NUL_C : CH_COMMA_C);
      end
    end
  endfunction

  function automatic void put_noise();
    int n = $urandom_range(5, 25);
    for (int i = 0; i < n; i++)
      put(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
  endfunction

  // Text source: one transaction per queued item
  task automatic send_text();
    text_item_t it;
    int gap;
    while (text_items.size() != 0) begin
      it = text_items.pop_front();
      gap = pick_gap(src_calm);
      if (gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      text_ch.valid     <= 1'b1;
      text_ch.text_char <= it.ch;
      text_ch.restart   <= it.rs;
      do @(posedge clk); while (!text_ch.ready);
      sb.take_text(it.ch, it.rs);
    end
    text_ch.valid <= 1'b0;
  endtask

  // Note sink with random stalls
  initial begin
    note_t got;
    int gap;
    note_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = pick_gap(snk_calm);
      if (gap > 0) begin
        note_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      note_ch.ready <= 1'b1;
      do @(posedge clk); while (!note_ch.valid);
      got.code     = note_ch.note_code;
      got.octave   = note_ch.octave_number;
      got.divisor  = note_ch.note_divisor;
      got.dotted   = note_ch.dotted;
      got.tempo    = note_ch.tempo_bpm;
      got.song_end = note_ch.song_end;
      sb.check_note(got);
    end
  end

  // Main sequence
  initial begin
    sb = new();
    text_ch.valid     = 1'b0;
    text_ch.text_char = '0;
    text_ch.restart   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: saturated tempo, sharp with dot and octave, bad sharp, empty note at end
    put("t", 1'b1);
    put_str(":d=32,o=6,b=99999:");
    put_str("a#.7,");
    put_str("e#,");
    put(CH_NUL_C);

    // Random ringtones with some noise, sent in one stream after the directed part
    while (text_items.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) put_noise();
      else put_song();
    end
    send_text();

    while (sb.expected_notes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
